[rtl/assert_macros.svh]
// Assertion macros used by pdns_core.
// Each macro is checked against clk and arst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PDNS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");
`define PDNS_ASSERT_IMPL(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`else
`define PDNS_ASSERT(lbl, prop)
`define PDNS_ASSERT_IMPL(lbl, pre, post)
`endif
`endif

[rtl/pdns_pkg.sv]
package pdns_pkg;

	localparam int CAPTURE_LIMIT = 16;
	localparam int LIST_FIELDS   = 4;

	localparam logic [7:0]  CHAR_COMMA = 8'h2C;
	localparam logic [7:0]  CHAR_MINUS = 8'h2D;
	localparam logic [7:0]  CHAR_PLUS  = 8'h2B;
	localparam logic [7:0]  CHAR_SPACE = 8'h20;
	localparam logic [7:0]  CHAR_ZERO  = 8'h30;
	localparam logic [7:0]  CHAR_NINE  = 8'h39;
	localparam logic [7:0]  CHAR_TAB   = 8'h09;
	localparam logic [7:0]  CHAR_CR    = 8'h0D;
	localparam logic [7:0]  CHAR_NUL   = 8'h00;

	localparam logic [31:0] ACC_MAX = 32'h8000_0000;
	localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] NO_VALUE = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		REG_PREAMBLE_BYTES  = 3'd0,
		REG_PREAMBLE_LENGTH = 3'd1,
		REG_DELIMITER_A     = 3'd2,
		REG_DELIMITER_B     = 3'd3,
		REG_SCAN_KIND       = 3'd4
	} reg_index_t;

	typedef enum logic [1:0] {
		KIND_INT   = 2'd0,
		KIND_FLOAT = 2'd1,
		KIND_LIST  = 2'd2,
		KIND_OTHER = 2'd3
	} scan_kind_t;

	typedef enum logic [1:0] {
		PHASE_SKIP   = 2'd0,
		PHASE_DIGITS = 2'd1,
		PHASE_DONE   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [63:0] preamble_bytes;
		logic [3:0]  preamble_length;
		logic [7:0]  delimiter_a;
		logic [7:0]  delimiter_b;
		logic [1:0]  scan_kind;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} stage_t;

endpackage

[rtl/pdns_byte_if.sv]
interface pdns_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

[rtl/pdns_result_if.sv]
interface pdns_result_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] int_value;
	logic signed [31:0] list_field_0;
	logic signed [31:0] list_field_1;
	logic signed [31:0] list_field_2;
	logic signed [31:0] list_field_3;

	modport source (output valid, output int_value, output list_field_0,
		output list_field_1, output list_field_2, output list_field_3, input ready);
	modport sink (input valid, input int_value, input list_field_0,
		input list_field_1, input list_field_2, input list_field_3, output ready);
endinterface

[rtl/pdns_in_stage.sv]
module pdns_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	pdns_byte_if.sink       rx,
	input  logic            take,
	output pdns_pkg::stage_t stage
);
	import pdns_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;

	assign rx.ready = !valid_s1 || take;
	assign stage.valid = valid_s1;
	assign stage.data = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			data_s1 <= rx.data_byte;
		end
	end
endmodule

[rtl/pdns_core.sv]
`include "assert_macros.svh"
module pdns_core (
	input  logic             clk,
	input  logic             arst_n,
	input  pdns_pkg::cfg_t   cfg,
	input  pdns_pkg::stage_t stage,
	output logic             take,
	pdns_result_if.source    res
);
	import pdns_pkg::*;

	logic        in_payload_q, in_payload_n;
	logic [4:0]  byte_count_q, byte_count_n;
	logic [31:0] acc_q, acc_n;
	phase_t      phase_q, phase_n;
	logic        negative_q, negative_n;
	logic [2:0]  field_index_q, field_index_n;
	logic        text_ended_q, text_ended_n;
	logic [LIST_FIELDS-1:0][31:0] pending_q, pending_n;
	logic [LIST_FIELDS-1:0][31:0] list_q, list_n;

	logic        out_valid_q;
	logic [31:0] out_int_q;
	logic [LIST_FIELDS-1:0][31:0] out_list_q;

	logic [7:0]  b;
	logic [3:0]  plen;
	logic [7:0]  expected;
	logic        emit;
	logic        restart;
	logic [31:0] cur_value;
	logic [35:0] product;
	logic        is_digit;
	logic        is_space;
	logic [31:0] ival;

	assign b = stage.data;
	assign emit = in_payload_q && (b == cfg.delimiter_a || b == cfg.delimiter_b);
	assign take = stage.valid && (!emit || !out_valid_q || res.ready);

	assign plen = (cfg.preamble_length == 4'd0) ? 4'd1 :
		(cfg.preamble_length > 4'd8) ? 4'd8 : cfg.preamble_length;
	assign expected = cfg.preamble_bytes[{byte_count_q[2:0], 3'b000} +: 8];
	assign cur_value = negative_q ? (32'd0 - acc_q) :
		((acc_q > POS_MAX) ? POS_MAX : acc_q);
	assign product = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) +
		{32'd0, b[3:0] - CHAR_ZERO[3:0]};
	assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
	assign is_space = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));

	always_comb begin
		in_payload_n = in_payload_q;
		byte_count_n = byte_count_q;
		acc_n = acc_q;
		phase_n = phase_q;
		negative_n = negative_q;
		field_index_n = field_index_q;
		text_ended_n = text_ended_q;
		pending_n = pending_q;
		list_n = list_q;
		restart = 1'b0;
		ival = NO_VALUE;
		if (!in_payload_q) begin
			if (b != expected) begin
				restart = 1'b1;
			end else begin
				byte_count_n = byte_count_q + 5'd1;
				if (byte_count_n >= {1'b0, plen}) begin
					in_payload_n = 1'b1;
				end
			end
		end else if (emit) begin
			if (field_index_q < 3'(LIST_FIELDS)) begin
				pending_n[field_index_q[1:0]] = cur_value;
			end
			if (cfg.scan_kind == KIND_LIST) begin
				for (int i = 0; i < LIST_FIELDS; i++) begin
					if (field_index_q >= 3'(LIST_FIELDS) || 3'(i) <= field_index_q) begin
						list_n[i] = pending_n[i];
					end
				end
			end
			if (cfg.scan_kind == KIND_INT || cfg.scan_kind == KIND_FLOAT) begin
				ival = pending_n[0];
			end
			restart = 1'b1;
		end else begin
			if (!text_ended_q && field_index_q < 3'(LIST_FIELDS)) begin
				if (b == CHAR_NUL) begin
					text_ended_n = 1'b1;
				end else if (b == CHAR_COMMA) begin
					pending_n[field_index_q[1:0]] = cur_value;
					field_index_n = field_index_q + 3'd1;
					acc_n = 32'd0;
					phase_n = PHASE_SKIP;
					negative_n = 1'b0;
				end else if (is_digit) begin
					if (phase_q != PHASE_DONE) begin
						acc_n = (product > {4'd0, ACC_MAX}) ? ACC_MAX : product[31:0];
						phase_n = PHASE_DIGITS;
					end
				end else if (phase_q == PHASE_SKIP && is_space) begin
					phase_n = PHASE_SKIP;
				end else if (phase_q == PHASE_SKIP && (b == CHAR_MINUS || b == CHAR_PLUS)) begin
					negative_n = (b == CHAR_MINUS);
					phase_n = PHASE_DIGITS;
				end else begin
					phase_n = PHASE_DONE;
				end
			end
			byte_count_n = byte_count_q + 5'd1;
			if (byte_count_n >= 5'(CAPTURE_LIMIT)) begin
				restart = 1'b1;
			end
		end
		if (restart) begin
			in_payload_n = 1'b0;
			byte_count_n = 5'd0;
			field_index_n = 3'd0;
			text_ended_n = 1'b0;
			acc_n = 32'd0;
			phase_n = PHASE_SKIP;
			negative_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			byte_count_q <= 5'd0;
			acc_q <= 32'd0;
			phase_q <= PHASE_SKIP;
			negative_q <= 1'b0;
			field_index_q <= 3'd0;
			text_ended_q <= 1'b0;
			pending_q <= '0;
			list_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				in_payload_q <= in_payload_n;
				byte_count_q <= byte_count_n;
				acc_q <= acc_n;
				phase_q <= phase_n;
				negative_q <= negative_n;
				field_index_q <= field_index_n;
				text_ended_q <= text_ended_n;
				pending_q <= pending_n;
				list_q <= list_n;
			end
			if (!out_valid_q || res.ready) begin
				out_valid_q <= take && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			out_int_q <= ival;
			out_list_q <= list_n;
		end
	end

	assign res.valid = out_valid_q;
	assign res.int_value = out_int_q;
	assign res.list_field_0 = out_list_q[0];
	assign res.list_field_1 = out_list_q[1];
	assign res.list_field_2 = out_list_q[2];
	assign res.list_field_3 = out_list_q[3];

	`PDNS_ASSERT(a_acc_bound, acc_q <= ACC_MAX)
	`PDNS_ASSERT(a_field_bound, field_index_q <= 3'(LIST_FIELDS))
	`PDNS_ASSERT(a_capture_bound, byte_count_q < 5'(CAPTURE_LIMIT))
	`PDNS_ASSERT_IMPL(a_preamble_count, !in_payload_q, byte_count_q < 5'd8)
	`PDNS_ASSERT_IMPL(a_emit_restarts, $past(take && emit), !in_payload_q)
endmodule

[rtl/preamble_delimited_number_scanner.sv]
// Preamble-delimited number scanner.
// rx carries one text byte per word; res carries one result word per payload
// closed by delimiter_a or delimiter_b: int_value and the four list fields.
// The block matches the configured preamble, then parses the payload like
// atoi, or as four comma-separated integers when scan_kind selects the list.
// Configuration is written through wr_en, wr_index and wr_data; the user
// must do so only while idle, which the block does not enforce. Throughput
// is one byte per cycle while no delimiter waits on res: every byte is
// handled by a single state update between the input register, which holds
// each accepted byte, and the result register, which holds any result.
// When res stalls, bytes that produce no result keep flowing; a delimiter
// byte waits in the input register until the pending result is taken, and
// rx then deasserts ready.
// Reset clears the match and parse state, the held list values and the
// configuration to its defaults; no result is pending after reset.
module preamble_delimited_number_scanner (
	input  logic          clk,
	input  logic          arst_n,
	pdns_byte_if.sink     rx,
	pdns_result_if.source res,
	input  logic          wr_en,
	input  logic [2:0]    wr_index,
	input  logic [63:0]   wr_data
);
	import pdns_pkg::*;

	cfg_t   cfg_q;
	stage_t stage;
	logic   take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.preamble_bytes <= 64'd0;
			cfg_q.preamble_length <= 4'd1;
			cfg_q.delimiter_a <= 8'd10;
			cfg_q.delimiter_b <= 8'd13;
			cfg_q.scan_kind <= KIND_FLOAT;
		end else if (wr_en) begin
			case (wr_index)
				REG_PREAMBLE_BYTES: cfg_q.preamble_bytes <= wr_data;
				REG_PREAMBLE_LENGTH: cfg_q.preamble_length <= wr_data[3:0];
				REG_DELIMITER_A: cfg_q.delimiter_a <= wr_data[7:0];
				REG_DELIMITER_B: cfg_q.delimiter_b <= wr_data[7:0];
				REG_SCAN_KIND: cfg_q.scan_kind <= wr_data[1:0];
				default: ;
			endcase
		end
	end

	pdns_in_stage u_in_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.take   (take),
		.stage  (stage)
	);

	pdns_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.stage  (stage),
		.take   (take),
		.res    (res)
	);
endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
	import pdns_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic [7:0] LINE_FEED = 8'h0A;

	typedef struct packed {
		logic signed [31:0] int_value;
		logic signed [31:0] list_field_0;
		logic signed [31:0] list_field_1;
		logic signed [31:0] list_field_2;
		logic signed [31:0] list_field_3;
	} scan_report_t;

	typedef struct {
		logic [7:0]   data;
		bit           typed;
		scan_report_t want;
	} stim_row_t;

	localparam scan_report_t SAT_HIGH = '{POS_MAX, 32'd0, 32'd0, 32'd0, 32'd0};
	localparam scan_report_t SAT_LOW  = '{ACC_MAX, 32'd0, 32'd0, 32'd0, 32'd0};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [63:0] wr_data;

	pdns_byte_if   byte_ch ();
	pdns_result_if report_ch ();

	preamble_delimited_number_scanner i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (byte_ch),
		.res      (report_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #5ns clk = ~clk;

	// Scanner state as the block should hold it.
	cfg_t         cfg;
	logic         matched;
	int unsigned  seen;
	logic [63:0]  magnitude;
	phase_t       num_phase;
	logic         minus;
	int unsigned  field_no;
	logic [31:0]  list_hold [LIST_FIELDS];
	logic [31:0]  list_new [LIST_FIELDS];
	logic         nul_seen;

	scan_report_t reports_due [$];
	stim_row_t    directed_rows [$];
	logic [7:0]   frame [$];
	int unsigned  burst_left;
	int unsigned  bytes_sent;
	int unsigned  cycles;
	int unsigned  mismatches;

	function automatic void clear_magnitude();
		magnitude = '0;
		num_phase = PHASE_SKIP;
		minus = 1'b0;
	endfunction

	function automatic void drop_capture();
		matched = 1'b0;
		seen = 0;
		field_no = 0;
		nul_seen = 1'b0;
		clear_magnitude();
	endfunction

	function automatic logic [31:0] field_value();
		if (minus)
			return 32'd0 - magnitude[31:0];
		if (magnitude > 64'(POS_MAX))
			return POS_MAX;
		return magnitude[31:0];
	endfunction

	function automatic void take_text(input logic [7:0] b);
		if (nul_seen || field_no >= LIST_FIELDS)
			return;
		if (b == CHAR_NUL) begin
			nul_seen = 1'b1;
			return;
		end
		if (b == CHAR_COMMA) begin
			list_new[field_no] = field_value();
			field_no++;
			clear_magnitude();
			return;
		end
		if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
			if (num_phase != PHASE_DONE) begin
				magnitude = magnitude * 64'd10 + 64'(b - CHAR_ZERO);
				if (magnitude > 64'(ACC_MAX))
					magnitude = 64'(ACC_MAX);
				num_phase = PHASE_DIGITS;
			end
			return;
		end
		if (num_phase == PHASE_SKIP) begin
			if (b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR))
				return;
			if (b == CHAR_MINUS || b == CHAR_PLUS) begin
				minus = (b == CHAR_MINUS);
				num_phase = PHASE_DIGITS;
				return;
			end
		end
		num_phase = PHASE_DONE;
	endfunction

	function automatic bit scan_byte(input logic [7:0] b, output scan_report_t r);
		int unsigned plen;
		int unsigned count;
		r = '0;
		if (!matched) begin
			plen = cfg.preamble_length;
			if (plen < 1)
				plen = 1;
			if (plen > 8)
				plen = 8;
			if (b != cfg.preamble_bytes[8 * (seen % 8) +: 8])
				drop_capture();
			else
				seen++;
			if (seen >= plen)
				matched = 1'b1;
			return 1'b0;
		end
		if (b == cfg.delimiter_a || b == cfg.delimiter_b) begin
			if (field_no < LIST_FIELDS) begin
				list_new[field_no] = field_value();
				count = field_no + 1;
			end else begin
				count = LIST_FIELDS;
			end
			if (cfg.scan_kind == KIND_LIST)
				for (int i = 0; i < count; i++)
					list_hold[i] = list_new[i];
			r.int_value = (cfg.scan_kind == KIND_INT || cfg.scan_kind == KIND_FLOAT) ?
				list_new[0] : NO_VALUE;
			r.list_field_0 = list_hold[0];
			r.list_field_1 = list_hold[1];
			r.list_field_2 = list_hold[2];
			r.list_field_3 = list_hold[3];
			drop_capture();
			return 1'b1;
		end
		take_text(b);
		seen++;
		if (seen >= CAPTURE_LIMIT)
			drop_capture();
		return 1'b0;
	endfunction

	function automatic void add_row(input logic [7:0] b, input bit typed = 1'b0,
		input scan_report_t want = '0);
		stim_row_t row;
		row.data = b;
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endfunction

	function automatic logic [7:0] pick_delimiter();
		case ($urandom_range(0, 3))
			0: begin
				return LINE_FEED;
			end
			1: begin
				return CHAR_CR;
			end
			default: begin
				return 8'($urandom_range(0, 255));
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input logic signed [31:0] want,
		input logic signed [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
		input scan_report_t want = '0);
		scan_report_t got;
		if (burst_left == 0) begin
			byte_ch.valid <= 1'b0;
			if ($urandom_range(0, 99) == 0)
				while (reports_due.size() != 0)
					@(posedge clk);
			repeat ($urandom_range(1, 6))
				@(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200) :
				$urandom_range(1, 12);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		burst_left--;
		bytes_sent++;
		if (scan_byte(b, got))
			reports_due.push_back(typed ? want : got);
	endtask

	// The block may still hold bytes that cause no word, so settle keeps waiting after the drain.
	task automatic settle();
		byte_ch.valid <= 1'b0;
		while (reports_due.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
		burst_left = 0;
	endtask

	task automatic configure(input logic [63:0] pre, input logic [3:0] plen,
		input logic [7:0] da, input logic [7:0] db, input scan_kind_t kind);
		logic [63:0] filler;
		filler = {$urandom, $urandom};
		wr_en <= 1'b1;
		wr_index <= REG_PREAMBLE_BYTES;
		wr_data <= pre;
		@(posedge clk);
		wr_index <= REG_PREAMBLE_LENGTH;
		wr_data <= {filler[63:4], plen};
		@(posedge clk);
		wr_index <= REG_DELIMITER_A;
		wr_data <= {filler[63:8], da};
		@(posedge clk);
		wr_index <= REG_DELIMITER_B;
		wr_data <= {filler[55:0], db};
		@(posedge clk);
		wr_index <= REG_SCAN_KIND;
		wr_data <= {filler[63:2], kind};
		@(posedge clk);
		wr_en <= 1'b0;
		cfg = '{pre, plen, da, db, kind};
	endtask

	task automatic build_frame();
		int unsigned plen;
		int unsigned budget;
		int unsigned commas;
		int unsigned n;
		logic [7:0] payload [$];
		frame.delete();
		plen = (cfg.preamble_length == 0) ? 1 :
			((cfg.preamble_length > 8) ? 8 : cfg.preamble_length);
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 4))
				frame.push_back(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 7) == 0) begin
			n = $urandom_range(0, plen - 1);
			for (int i = 0; i < n; i++)
				frame.push_back(cfg.preamble_bytes[8 * i +: 8]);
			frame.push_back(cfg.preamble_bytes[8 * n +: 8] ^ 8'($urandom_range(1, 255)));
		end
		for (int i = 0; i < plen; i++)
			frame.push_back(cfg.preamble_bytes[8 * i +: 8]);
		commas = (cfg.scan_kind == KIND_LIST) ? $urandom_range(0, 6) :
			(($urandom_range(0, 4) == 0) ? 1 : 0);
		for (int f = 0; f <= commas; f++) begin
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 2))
					payload.push_back($urandom_range(0, 1) ? CHAR_SPACE :
						8'($urandom_range(9, 13)));
			case ($urandom_range(0, 3))
				0: begin
					payload.push_back(CHAR_MINUS);
				end
				1: begin
					payload.push_back(CHAR_PLUS);
				end
				default: begin
				end
			endcase
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 3);
			for (int i = 0; i < n; i++)
				payload.push_back((n >= 10 && i == 0) ? CHAR_NINE :
					8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
			if ($urandom_range(0, 5) == 0)
				payload.push_back(8'($urandom_range(0, 255)));
			if (f < commas)
				payload.push_back(CHAR_COMMA);
		end
		if (payload.size() != 0 && $urandom_range(0, 9) == 0)
			payload[$urandom_range(0, payload.size() - 1)] = CHAR_NUL;
		budget = CAPTURE_LIMIT - 1 - plen;
		if ($urandom_range(0, 9) != 0)
			while (payload.size() > budget)
				void'(payload.pop_back());
		foreach (payload[i])
			frame.push_back(payload[i]);
		frame.push_back($urandom_range(0, 1) ? cfg.delimiter_a : cfg.delimiter_b);
	endtask

	initial begin
		int unsigned pattern_left;
		int unsigned pattern_kind;
		report_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (pattern_left == 0) begin
				pattern_kind = $urandom_range(0, 3);
				pattern_left = $urandom_range(8, 80);
			end
			pattern_left--;
			case (pattern_kind)
				0: begin
					report_ch.ready <= 1'b1;
				end
				1: begin
					report_ch.ready <= ($urandom_range(0, 3) != 0);
				end
				2: begin
					report_ch.ready <= (pattern_left % 5 == 0);
				end
				default: begin
					report_ch.ready <= (pattern_left < 3);
				end
			endcase
		end
	end

	always @(posedge clk) begin : report_check
		scan_report_t want;
		if (arst_n && report_ch.valid && report_ch.ready) begin
			if (reports_due.size() == 0) begin
				$display("%0t: word expected none, got int_value %0d", $time,
					report_ch.int_value);
				mismatches++;
			end else begin
				want = reports_due.pop_front();
				check_field("int_value", want.int_value, report_ch.int_value);
				check_field("list_field_0", want.list_field_0, report_ch.list_field_0);
				check_field("list_field_1", want.list_field_1, report_ch.list_field_1);
				check_field("list_field_2", want.list_field_2, report_ch.list_field_2);
				check_field("list_field_3", want.list_field_3, report_ch.list_field_3);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		logic [63:0] pre;
		logic [3:0]  plen;
		logic [7:0]  da;
		logic [7:0]  db;
		scan_kind_t  kind;
		int unsigned phase_no;
		arst_n <= 1'b0;
		byte_ch.valid <= 1'b0;
		byte_ch.data_byte <= CHAR_NUL;
		wr_en <= 1'b0;
		wr_index <= REG_PREAMBLE_BYTES;
		wr_data <= '0;

		cfg = '{64'd0, 4'd1, LINE_FEED, CHAR_CR, KIND_FLOAT};
		for (int i = 0; i < LIST_FIELDS; i++) begin
			list_hold[i] = '0;
			list_new[i] = '0;
		end
		drop_capture();

		// Reset preamble is a single zero byte; both numbers saturate.
		add_row(CHAR_NUL);
		repeat (10)
			add_row(CHAR_NINE);
		add_row(LINE_FEED, 1'b1, SAT_HIGH);
		add_row(CHAR_NUL);
		add_row(CHAR_MINUS);
		repeat (10)
			add_row(CHAR_NINE);
		add_row(CHAR_CR, 1'b1, SAT_LOW);

		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);

		phase_no = 0;
		while (bytes_sent < 450 && phase_no < 200) begin
			settle();
			case (phase_no)
				0: begin
					pre = '1;
					plen = 4'd15;
					da = CHAR_NUL;
					db = 8'hFF;
					kind = KIND_LIST;
				end
				1: begin
					pre = '0;
					plen = 4'd0;
					da = 8'hFF;
					db = CHAR_NUL;
					kind = KIND_INT;
				end
				2: begin
					pre = {$urandom, $urandom};
					plen = 4'd8;
					da = LINE_FEED;
					db = CHAR_CR;
					kind = KIND_OTHER;
				end
				default: begin
					pre = {$urandom, $urandom};
					plen = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
						4'($urandom_range(1, 3));
					da = pick_delimiter();
					db = pick_delimiter();
					kind = scan_kind_t'(2'($urandom_range(0, 3)));
				end
			endcase
			configure(pre, plen, da, db, kind);
			repeat (8) begin
				build_frame();
				foreach (frame[i])
					send_byte(frame[i]);
			end
			phase_no++;
		end

		settle();
		repeat (8)
			@(posedge clk);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

[sim.f]
+incdir+rtl
rtl/pdns_pkg.sv
rtl/pdns_byte_if.sv
rtl/pdns_result_if.sv
rtl/pdns_in_stage.sv
rtl/pdns_core.sv
rtl/preamble_delimited_number_scanner.sv
dv/tb_top.sv
